FILE: src/ppq_pkg.sv
// ----------------------------------------------------------------------------
// ppq_pkg
// shared types, sizes and codes of the priority packet queue
// ----------------------------------------------------------------------------
package ppq_pkg;

    // number of slots held by the queue
    localparam int SLOTS  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // field widths
    localparam int PRIO_W = 2;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;
    localparam int OVF_W  = 32;
    localparam int THR_W  = 2;

    // depth of the command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // reset value of the eviction threshold
    localparam logic [THR_W-1:0] THR_RESET = 2'd2;

    // request types
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]  packet_tag;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  out_tag;
        logic [PRIO_W-1:0] out_priority;
        logic              evicted;
        logic [TAG_W-1:0]  evicted_tag;
        logic [OCC_W-1:0]  occupancy;
        logic [OVF_W-1:0]  overflow_total;
    } rsp_t;

    // classified command handed from front to back
    typedef struct packed {
        logic              deq;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

endpackage

FILE: src/ppq_front.sv
// ----------------------------------------------------------------------------
// ppq_front
// accepts request transactions, classifies them and queues them for the back
// ----------------------------------------------------------------------------
module ppq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ppq_pkg::req_t req,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output ppq_pkg::cmd_t cmd
);

    logic [ppq_pkg::QPTR_W-1:0] head_reg, head_next;
    logic [ppq_pkg::QPTR_W-1:0] tail_reg, tail_next;
    logic [ppq_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    ppq_pkg::cmd_t              q_reg [ppq_pkg::QDEPTH];
    ppq_pkg::cmd_t              cmd_in;
    logic                       push;
    logic                       pop;

    assign req_ready = (cnt_reg != ppq_pkg::QCNT_W'(ppq_pkg::QDEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[head_reg];
    assign push      = req_valid && req_ready;
    assign pop       = cmd_valid && cmd_ready;

    // classify
    always_comb
    begin
        cmd_in.deq  = (req.req_type == ppq_pkg::REQ_DEQ);
        cmd_in.prio = req.priority_req;
        cmd_in.tag  = req.packet_tag;
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            tail_next = (tail_reg == ppq_pkg::QPTR_W'(ppq_pkg::QDEPTH - 1)) ? '0
                                                                             : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == ppq_pkg::QPTR_W'(ppq_pkg::QDEPTH - 1)) ? '0
                                                                             : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[tail_reg] <= cmd_in;
        end
    end

endmodule

FILE: src/ppq_back.sv
// ----------------------------------------------------------------------------
// ppq_back
// slot store, slot selection and update, result register
// ----------------------------------------------------------------------------
module ppq_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ppq_pkg::THR_W-1:0]     cfg_wdata,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  ppq_pkg::cmd_t                 cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output ppq_pkg::rsp_t                 rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    localparam logic [2:0] ACT_ENQ   = 3'd0;
    localparam logic [2:0] ACT_EVICT = 3'd1;
    localparam logic [2:0] ACT_OVF   = 3'd2;
    localparam logic [2:0] ACT_DEQ   = 3'd3;
    localparam logic [2:0] ACT_EMPTY = 3'd4;

    // slot state
    logic [ppq_pkg::SLOTS-1:0]  valid_reg, valid_next;
    logic [ppq_pkg::PRIO_W-1:0] slot_prio_reg [ppq_pkg::SLOTS];
    logic [ppq_pkg::TAG_W-1:0]  tag_mem [ppq_pkg::SLOTS];
    logic [ppq_pkg::IDX_W-1:0]  wp_reg, wp_next;
    logic [ppq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ppq_pkg::OVF_W-1:0]  ovf_cnt_reg, ovf_cnt_next;
    logic [ppq_pkg::THR_W-1:0]  thr_reg;

    logic                       state_reg, state_next;

    // selection results held for the update cycle
    logic [2:0]                 act_reg, act_next;
    logic [ppq_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [ppq_pkg::PRIO_W-1:0] prio_reg, prio_next;
    logic [ppq_pkg::TAG_W-1:0]  tag_reg;
    logic [ppq_pkg::TAG_W-1:0]  rd_tag_reg;

    logic                       rsp_valid_reg, rsp_valid_next;
    ppq_pkg::rsp_t              rsp_reg, rsp_next;

    logic                       start;
    logic                       finish;
    logic                       full;

    logic                       evict_hit;
    logic [ppq_pkg::IDX_W-1:0]  evict_idx;
    logic                       any_up;
    logic [ppq_pkg::IDX_W-1:0]  free_up;
    logic [ppq_pkg::IDX_W-1:0]  free_low;
    logic [3:0]                 lvl_any;
    logic                       best_found;
    logic [ppq_pkg::PRIO_W-1:0] best_prio;
    logic [ppq_pkg::IDX_W-1:0]  win_idx;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign start     = cmd_valid && cmd_ready;
    assign finish    = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign full      = (count_reg == ppq_pkg::CNT_W'(ppq_pkg::SLOTS));
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // parallel slot searches
    always_comb
    begin
        evict_hit = 1'b0;
        evict_idx = '0;
        any_up    = 1'b0;
        free_up   = '0;
        free_low  = '0;
        lvl_any   = '0;
        // descending so the lowest qualifying index is kept
        for (int i = ppq_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (slot_prio_reg[i] < cmd.prio))
            begin
                evict_hit = 1'b1;
                evict_idx = ppq_pkg::IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_low = ppq_pkg::IDX_W'(i);
                if (ppq_pkg::IDX_W'(i) >= wp_reg)
                begin
                    any_up  = 1'b1;
                    free_up = ppq_pkg::IDX_W'(i);
                end
            end
        end
        for (int i = 0; i < ppq_pkg::SLOTS; i++)
        begin
            if (valid_reg[i])
            begin
                lvl_any[slot_prio_reg[i]] = 1'b1;
            end
        end
    end

    always_comb
    begin
        best_found = (lvl_any != '0);
        if (lvl_any[3])
        begin
            best_prio = 2'd3;
        end
        else if (lvl_any[2])
        begin
            best_prio = 2'd2;
        end
        else if (lvl_any[1])
        begin
            best_prio = 2'd1;
        end
        else
        begin
            best_prio = 2'd0;
        end
        // ascending so ties go to the highest index
        win_idx = '0;
        for (int i = 0; i < ppq_pkg::SLOTS; i++)
        begin
            if (valid_reg[i] && (slot_prio_reg[i] == best_prio))
            begin
                win_idx = ppq_pkg::IDX_W'(i);
            end
        end
    end

    // classify the command against the slot state
    always_comb
    begin
        act_next  = act_reg;
        idx_next  = idx_reg;
        prio_next = prio_reg;
        if (start)
        begin
            prio_next = cmd.prio;
            if (cmd.deq)
            begin
                act_next  = best_found ? ACT_DEQ : ACT_EMPTY;
                idx_next  = win_idx;
                prio_next = best_prio;
            end
            else if (full)
            begin
                if ((cmd.prio >= thr_reg) && evict_hit)
                begin
                    act_next = ACT_EVICT;
                    idx_next = evict_idx;
                end
                else
                begin
                    act_next = ACT_OVF;
                end
            end
            else
            begin
                act_next = ACT_ENQ;
                idx_next = any_up ? free_up : free_low;
            end
        end
    end

    // update and result
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        wp_next        = wp_reg;
        count_next     = count_reg;
        ovf_cnt_next   = ovf_cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (start)
        begin
            state_next = ST_EXEC;
        end
        if (finish)
        begin
            state_next          = ST_IDLE;
            rsp_valid_next      = 1'b1;
            rsp_next            = '0;
            rsp_next.status     = ppq_pkg::STATUS_OK;
            case (act_reg)
                ACT_ENQ:
                begin
                    valid_next[idx_reg] = 1'b1;
                    count_next          = count_reg + 1'b1;
                end
                ACT_EVICT:
                begin
                    // evicted slot is refilled at once, count stays
                    rsp_next.evicted     = 1'b1;
                    rsp_next.evicted_tag = rd_tag_reg;
                end
                ACT_OVF:
                begin
                    rsp_next.status = ppq_pkg::STATUS_OVERFLOW;
                    ovf_cnt_next    = ovf_cnt_reg + 1'b1;
                end
                ACT_DEQ:
                begin
                    valid_next[idx_reg]   = 1'b0;
                    count_next            = count_reg - 1'b1;
                    rsp_next.out_tag      = rd_tag_reg;
                    rsp_next.out_priority = prio_reg;
                end
                default:
                begin
                    rsp_next.status = ppq_pkg::STATUS_EMPTY;
                end
            endcase
            if ((act_reg == ACT_ENQ) || (act_reg == ACT_EVICT))
            begin
                wp_next = (idx_reg == ppq_pkg::IDX_W'(ppq_pkg::SLOTS - 1)) ? '0
                                                                           : idx_reg + 1'b1;
            end
            rsp_next.occupancy      = ppq_pkg::OCC_W'(count_next);
            rsp_next.overflow_total = ovf_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            ovf_cnt_reg   <= '0;
            thr_reg       <= ppq_pkg::THR_RESET;
            rsp_valid_reg <= 1'b0;
            act_reg       <= ACT_EMPTY;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            ovf_cnt_reg   <= ovf_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            act_reg       <= act_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        prio_reg <= prio_next;
        rsp_reg  <= rsp_next;
        if (start)
        begin
            tag_reg    <= cmd.tag;
            rd_tag_reg <= tag_mem[idx_next];
        end
        if (finish && ((act_reg == ACT_ENQ) || (act_reg == ACT_EVICT)))
        begin
            tag_mem[idx_reg]       <= tag_reg;
            slot_prio_reg[idx_reg] <= prio_reg;
        end
    end

    // occupancy never exceeds the slot count
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ppq_pkg::CNT_W'(ppq_pkg::SLOTS))
        else $error("entry count above slot count");

    // entry count tracks the valid flags
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count out of step with valid flags");

    // a finished transaction always leaves a result
    assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> rsp_valid_reg)
        else $error("result lost at finish");

    // overflow bumps the counter by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (act_reg == ACT_OVF)) |=> (ovf_cnt_reg == $past(ovf_cnt_reg) + 1'b1))
        else $error("overflow counter not bumped");

    // no new command is taken while one is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !cmd_ready)
        else $error("command taken while busy");

endmodule

FILE: src/priority_packet_queue_evict.sv
// ----------------------------------------------------------------------------
// priority_packet_queue_evict
// slot based priority queue of packet tags with eviction on a full queue
// ----------------------------------------------------------------------------
// Each request transaction gives exactly one result transaction, in order.
// An enqueue takes the first free slot from the write pointer onward; into a
// full queue it may evict the lowest-index entry of lower priority when its
// own priority is at least evict_threshold, and otherwise it is rejected
// with status overflow and the overflow counter counts up. A dequeue returns
// the entry of highest priority, the highest slot index winning ties, or
// status empty. The back end handles one request at a time: while the
// command sits at the head of the two-entry command queue, all slots are
// searched in parallel and the selection is registered; then, in the execute
// state and once the result register is free, the slots are updated and the
// result register is loaded. No new command is taken until that is done.
// Write evict_threshold only while the block is idle.
// ----------------------------------------------------------------------------
module priority_packet_queue_evict (
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      req_valid,
    output logic                      req_ready,
    input  ppq_pkg::req_t             req,
    // result channel
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output ppq_pkg::rsp_t             rsp,
    // evict_threshold write port
    input  logic                      cfg_we,
    input  logic [ppq_pkg::THR_W-1:0] cfg_wdata
);

    // command queue between front and back
    logic          cmd_valid;
    logic          cmd_ready;
    ppq_pkg::cmd_t cmd;

    // front: takes request transactions and queues classified commands
    ppq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // back: slot store, select and update, result register
    ppq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
